/* rtl/ac_rms_after_settle_macros.svh */
// Assertion macros used by the RTL top level.
// Clock and reset names are taken from the including scope (clk, rst_n).
`ifndef AC_RMS_AFTER_SETTLE_MACROS_SVH
`define AC_RMS_AFTER_SETTLE_MACROS_SVH

`ifndef SYNTHESIS
`define ACR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ACR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ACR_ASSERT_IMP(lbl, ante, cons, msg)
`define ACR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/acrms_pkg.sv */
package acrms_pkg;

    localparam int unsigned DEF_MAX_SAMPLES  = 1024;
    localparam int unsigned DEF_SAMPLE_WIDTH = 16;
    localparam int unsigned QUEUE_DEPTH      = 2;

    localparam int unsigned IN_W   = 16;
    localparam int unsigned SKIP_W = 10;
    localparam int unsigned POS_W  = 11;
    localparam int unsigned RMS_W  = 16;
    localparam int unsigned STAT_W = 2;

    localparam logic [POS_W-1:0] POS_CAP = 11'd1024;
    localparam logic [RMS_W-1:0] RMS_SAT = 16'hFFFF;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [RMS_W-1:0]  rms;
        logic [STAT_W-1:0] status;
    } result_t;

    // width of the accepted-sample count
    function automatic int cnt_w(input int max_samples);
        return $clog2(max_samples + 1);
    endfunction

    // signed width of the running sum
    function automatic int sum_w(input int sample_w, input int max_samples);
        return sample_w + $clog2(max_samples) + 1;
    endfunction

    // width of the running sum of squares
    function automatic int sq_w(input int sample_w, input int max_samples);
        return 2 * sample_w - 1 + $clog2(max_samples);
    endfunction

    // width of N*Q - S^2, rounded up to even for the root
    function automatic int d_w(input int sample_w, input int max_samples);
        int w;
        w = cnt_w(max_samples) + sq_w(sample_w, max_samples);
        return w + (w % 2);
    endfunction

    function automatic int rec_w(input int sample_w, input int max_samples);
        return cnt_w(max_samples) + sum_w(sample_w, max_samples)
            + sq_w(sample_w, max_samples) + 1;
    endfunction

endpackage

/* rtl/acrms_front.sv */
module acrms_front #(
    parameter int MAX_SAMPLES  = acrms_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_WIDTH = acrms_pkg::DEF_SAMPLE_WIDTH,
    parameter int REC_W        = acrms_pkg::rec_w(SAMPLE_WIDTH, MAX_SAMPLES)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [acrms_pkg::SKIP_W-1:0]     cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [acrms_pkg::IN_W-1:0] sample,
    input  logic                             last_sample,
    input  logic                             q_full,
    output logic                             push,
    output logic [REC_W-1:0]                 push_rec
);

    localparam int NW    = acrms_pkg::cnt_w(MAX_SAMPLES);
    localparam int SUMW  = acrms_pkg::sum_w(SAMPLE_WIDTH, MAX_SAMPLES);
    localparam int QW    = acrms_pkg::sq_w(SAMPLE_WIDTH, MAX_SAMPLES);
    localparam int RAW_W = (SAMPLE_WIDTH > acrms_pkg::IN_W) ? SAMPLE_WIDTH : acrms_pkg::IN_W;

    logic [acrms_pkg::SKIP_W-1:0] skip_reg;
    logic [acrms_pkg::POS_W-1:0]  idx_reg, idx_next;
    logic [NW-1:0]                cnt_reg, cnt_next;
    logic signed [SUMW-1:0]       sum_reg, sum_next;
    logic [QW-1:0]                sq_reg, sq_next;
    logic                         ovf_reg, ovf_next;

    logic [RAW_W-1:0]               raw;
    logic [SAMPLE_WIDTH-1:0]        raw_s;
    logic signed [SAMPLE_WIDTH-1:0] x;
    logic [SAMPLE_WIDTH-1:0]        mag;
    logic [2*SAMPLE_WIDTH-1:0]      mag_sq;
    logic                           take, room, accept;

    // the low SAMPLE_WIDTH bits of the port form the sample
    assign raw    = RAW_W'($unsigned(sample));
    assign raw_s  = raw[SAMPLE_WIDTH-1:0];
    assign x      = signed'(raw_s);
    assign mag    = raw_s[SAMPLE_WIDTH-1] ? (~raw_s + 1'b1) : raw_s;
    assign mag_sq = (2*SAMPLE_WIDTH)'(mag) * (2*SAMPLE_WIDTH)'(mag);

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign take     = idx_reg >= acrms_pkg::POS_W'(skip_reg);
    assign room     = cnt_reg < NW'(MAX_SAMPLES);

    always_comb
    begin
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        sq_next  = sq_reg;
        ovf_next = ovf_reg;
        if (take)
        begin
            if (room)
            begin
                cnt_next = cnt_reg + 1'b1;
                sum_next = sum_reg + SUMW'(x);
                sq_next  = sq_reg + QW'(mag_sq);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        idx_next = (idx_reg == acrms_pkg::POS_CAP) ? idx_reg : idx_reg + 1'b1;
    end

    assign push     = accept && last_sample;
    assign push_rec = {cnt_next, sum_next, sq_next, ovf_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= '0;
            idx_reg  <= '0;
            cnt_reg  <= '0;
            sum_reg  <= '0;
            sq_reg   <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                skip_reg <= cfg_data;
            end
            if (accept)
            begin
                if (last_sample)
                begin
                    idx_reg <= '0;
                    cnt_reg <= '0;
                    sum_reg <= '0;
                    sq_reg  <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_next;
                    cnt_reg <= cnt_next;
                    sum_reg <= sum_next;
                    sq_reg  <= sq_next;
                    ovf_reg <= ovf_next;
                end
            end
        end
    end

endmodule

/* rtl/acrms_fifo.sv */
module acrms_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = acrms_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full  = count_reg == CW'(DEPTH);
    assign empty = count_reg == '0;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/acrms_back.sv */
module acrms_back #(
    parameter int MAX_SAMPLES  = acrms_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_WIDTH = acrms_pkg::DEF_SAMPLE_WIDTH,
    parameter int REC_W        = acrms_pkg::rec_w(SAMPLE_WIDTH, MAX_SAMPLES)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  logic [REC_W-1:0]               q_rec,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [acrms_pkg::RMS_W-1:0]    rms_level,
    output logic [acrms_pkg::STAT_W-1:0]   status
);

    localparam int NW    = acrms_pkg::cnt_w(MAX_SAMPLES);
    localparam int SUMW  = acrms_pkg::sum_w(SAMPLE_WIDTH, MAX_SAMPLES);
    localparam int QW    = acrms_pkg::sq_w(SAMPLE_WIDTH, MAX_SAMPLES);
    localparam int DW    = acrms_pkg::d_w(SAMPLE_WIDTH, MAX_SAMPLES);
    localparam int RW    = DW / 2;
    localparam int MAGW  = SUMW - 1;
    localparam int MW    = (NW > MAGW) ? NW : MAGW;
    localparam int ITMAX = (MW > RW) ? MW : RW;
    localparam int ITW   = $clog2(ITMAX + 1);
    localparam int QX    = (RW > acrms_pkg::RMS_W) ? RW : acrms_pkg::RMS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUB,
        S_SQRT,
        S_DIV,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [ITW-1:0]         it_reg;
    logic [NW-1:0]          n_reg, nsh_reg;
    logic [MAGW-1:0]        msh_reg;
    logic [DW-1:0]          qsh_reg, ssh_reg, nq_reg, ss_reg;
    logic [RW:0]            srem_reg;
    logic [RW-1:0]          root_reg;
    logic [NW-1:0]          drem_reg;
    logic                   ovf_reg, empty_reg;
    logic                   out_valid_reg;
    acrms_pkg::result_t     out_reg;

    // record fields
    logic [NW-1:0]          rec_cnt;
    logic signed [SUMW-1:0] rec_sum;
    logic [QW-1:0]          rec_sq;
    logic                   rec_ovf;
    logic [MAGW-1:0]        rec_smag;

    // step logic
    logic [RW+2:0]          sq_rt, sq_trial;
    logic                   sq_ge;
    logic [NW:0]            dv_rt;
    logic                   dv_ge;
    logic [QX-1:0]          quo_x;
    logic [acrms_pkg::RMS_W-1:0] rms_sat;
    logic                   load_out;

    assign {rec_cnt, rec_sum, rec_sq, rec_ovf} = q_rec;
    assign rec_smag = rec_sum[SUMW-1] ? MAGW'(-rec_sum) : MAGW'(rec_sum);

    assign pop = (state_reg == S_IDLE) && !q_empty;

    // one root bit per step, restoring
    assign sq_rt    = {srem_reg, nq_reg[DW-1 -: 2]};
    assign sq_trial = (RW+3)'({root_reg, 2'b01});
    assign sq_ge    = sq_rt >= sq_trial;

    // one quotient bit per step, restoring
    assign dv_rt = {drem_reg, root_reg[RW-1]};
    assign dv_ge = dv_rt >= (NW+1)'(n_reg);

    assign quo_x   = QX'(root_reg);
    assign rms_sat = (quo_x > QX'(acrms_pkg::RMS_SAT)) ? acrms_pkg::RMS_SAT
                                                         : quo_x[acrms_pkg::RMS_W-1:0];

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            it_reg        <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        n_reg     <= rec_cnt;
                        nsh_reg   <= rec_cnt;
                        msh_reg   <= rec_smag;
                        qsh_reg   <= DW'(rec_sq);
                        ssh_reg   <= DW'(rec_smag);
                        nq_reg    <= '0;
                        ss_reg    <= '0;
                        ovf_reg   <= rec_ovf;
                        empty_reg <= rec_cnt == '0;
                        it_reg    <= '0;
                        state_reg <= (rec_cnt == '0) ? S_DONE : S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (nsh_reg[0])
                    begin
                        nq_reg <= nq_reg + qsh_reg;
                    end
                    if (msh_reg[0])
                    begin
                        ss_reg <= ss_reg + ssh_reg;
                    end
                    qsh_reg <= qsh_reg << 1;
                    ssh_reg <= ssh_reg << 1;
                    nsh_reg <= nsh_reg >> 1;
                    msh_reg <= msh_reg >> 1;
                    it_reg  <= it_reg + 1'b1;
                    if (it_reg == ITW'(MW - 1))
                    begin
                        state_reg <= S_SUB;
                    end
                end
                S_SUB:
                begin
                    // S^2 never exceeds N*Q, so the difference is exact
                    nq_reg    <= nq_reg - ss_reg;
                    srem_reg  <= '0;
                    root_reg  <= '0;
                    it_reg    <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    srem_reg <= sq_ge ? (RW+1)'(sq_rt - sq_trial) : (RW+1)'(sq_rt);
                    root_reg <= {root_reg[RW-2:0], sq_ge};
                    nq_reg   <= nq_reg << 2;
                    if (it_reg == ITW'(RW - 1))
                    begin
                        drem_reg  <= '0;
                        it_reg    <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        it_reg <= it_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    drem_reg <= dv_ge ? NW'(dv_rt - (NW+1)'(n_reg)) : NW'(dv_rt);
                    root_reg <= {root_reg[RW-2:0], dv_ge};
                    it_reg   <= it_reg + 1'b1;
                    if (it_reg == ITW'(RW - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        if (empty_reg)
                        begin
                            out_reg.rms    <= '0;
                            out_reg.status <= acrms_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            out_reg.rms    <= rms_sat;
                            out_reg.status <= ovf_reg ? acrms_pkg::ST_OVERFLOW
                                                      : acrms_pkg::ST_OK;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign rms_level = out_reg.rms;
    assign status    = out_reg.status;

endmodule

/* rtl/ac_rms_after_settle.sv */
// Mean-removed RMS over one block of signed samples. Samples are taken one
// per cycle on the input request channel; the last sample of a block is
// marked by last_sample. The first settle_skip samples of each block are
// ignored, then up to MAX_SAMPLES samples are counted into N, a sum S and a
// sum of squares Q. When a block ends its totals go into a two-entry queue
// and accumulation of the next block starts at once. A back end works each
// queued block out exactly in integers, floor(floor(sqrt(N*Q - S^2)) / N),
// and offers one result request with status ok, empty (nothing after the
// skip, rms 0) or overflow (samples beyond MAX_SAMPLES dropped). rms_level
// saturates at 65535. Timing: the front end takes one sample per cycle,
// stalling only while both queue entries are full. The back end is a shift-
// add multiplier, a radix-2 square root and a restoring divider run in turn;
// it takes the next queued block only once the last result is in its output
// register, and an empty block skips straight to that register. settle_skip
// is written over the cfg request channel; the user must write it only while
// the block is idle, as the block itself has no check for this; a new value
// applies from the next sample, against its position in the block.
module ac_rms_after_settle #(
    parameter int MAX_SAMPLES  = acrms_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_WIDTH = acrms_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration: settle_skip
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [acrms_pkg::SKIP_W-1:0]      cfg_data,
    // sample requests
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [acrms_pkg::IN_W-1:0] sample,
    input  logic                              last_sample,
    // result requests
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [acrms_pkg::RMS_W-1:0]       rms_level,
    output logic [acrms_pkg::STAT_W-1:0]      status
);

`include "ac_rms_after_settle_macros.svh"

    localparam int REC_W = acrms_pkg::rec_w(SAMPLE_WIDTH, MAX_SAMPLES);

    logic             push, pop;
    logic             q_full, q_empty;
    logic [REC_W-1:0] push_rec, q_rec;

    // the skip register is always free to take a write
    assign cfg_ready = 1'b1;

    // front end: settle skip, count, sum, sum of squares
    acrms_front #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .REC_W        (REC_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .last_sample (last_sample),
        .q_full      (q_full),
        .push        (push),
        .push_rec    (push_rec)
    );

    // per-block totals waiting for the back end
    acrms_fifo #(
        .WIDTH (REC_W),
        .DEPTH (acrms_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_rec),
        .pop   (pop),
        .rdata (q_rec),
        .full  (q_full),
        .empty (q_empty)
    );

    // back end: N*Q - S^2, root, divide by N, output register
    acrms_back #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .REC_W        (REC_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rec     (q_rec),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rms_level (rms_level),
        .status    (status)
    );

    // the back end only takes a record that is there
    `ACR_ASSERT_IMP(a_pop_has_data, pop, !q_empty, "queue popped while empty")

    // a pushed record is visible to the back end next cycle
    `ACR_ASSERT_NEXT(a_push_lands, push && !pop, !q_empty, "pushed record lost")

    // an empty block reports zero
    `ACR_ASSERT_IMP(a_empty_zero, out_valid && status == acrms_pkg::ST_EMPTY,
                    rms_level == '0, "empty block with nonzero rms")

endmodule
